// ===== rtl/core/rect_boundary_edge_endpoint_core_assert.svh =====
// Assertion macros for the rect boundary endpoint core
`ifndef RECT_BOUNDARY_EDGE_ENDPOINT_CORE_ASSERT_SVH
`define RECT_BOUNDARY_EDGE_ENDPOINT_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication, sampled on clk, off while arst_n is low
`define RBE_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rbe: implication check failed");
// next-cycle implication
`define RBE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rbe: next-cycle check failed");
`else
`define RBE_ASSERT_IMPL(lbl, ante, cons)
`define RBE_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/core/rbe_pkg.sv =====
// Types and constants shared by the rect boundary endpoint core
package rbe_pkg;

	localparam int FRAC_BITS = 8;

	localparam int POS_W = 23;          // box corner coordinate
	localparam int SW    = 22;          // box size
	localparam int PW    = 16;          // padding
	localparam int GW    = 16;          // gap threshold register
	localparam int OUTW  = 24;          // endpoint coordinate

	localparam int CW   = POS_W + 2;    // doubled centre, half-LSB units
	localparam int AW   = CW;           // centre distance magnitude per axis
	localparam int DW   = 26;           // floor of Euclidean distance
	localparam int SQW  = 2 * DW;       // squared distance, padded to whole digit pairs
	localparam int SQ_N = DW;           // square root iterations
	localparam int RMW  = DW + 2;       // square root remainder

	localparam int RQW  = 23;           // box radius
	localparam int RNW  = SW + DW;      // radius dividend
	localparam int SUMW = RQW + 2;      // sum of both radii and gap
	localparam int TW   = 24;           // radius with padding
	localparam int PXW  = TW + AW;      // radius times axis distance
	localparam int ONW  = PXW + 2;      // rounded offset dividend
	localparam int ODW  = DW + 1;       // rounded offset divisor
	localparam int OQW  = 24;           // offset magnitude
	localparam int FW   = CW + 2;       // endpoint before halving

	localparam int unsigned GAP_RESET_FULL = 10 << FRAC_BITS;
	localparam logic [GW-1:0] GAP_RESET =
		(GAP_RESET_FULL > 65535) ? {GW{1'b1}} : GW'(GAP_RESET_FULL);

	typedef struct packed {
		logic                 coin;
		logic                 sx;
		logic                 sy;
		logic signed [CW-1:0] bx;
		logic signed [CW-1:0] by;
		logic [AW-1:0]        adx;
		logic [AW-1:0]        ady;
		logic [PW-1:0]        pad;
	} pt_t;

	typedef struct packed {
		logic [SW-1:0] mw;
		logic [SW-1:0] mh;
		logic [SW-1:0] ow;
		logic [SW-1:0] oh;
	} sizes_t;

	typedef struct packed {
		pt_t    pt;
		sizes_t sz;
		logic   sel_m;
		logic   sel_o;
	} sq_side_t;

	typedef struct packed {
		pt_t           pt;
		logic [DW-1:0] d;
	} rd_side_t;

	typedef struct packed {
		pt_t  pt;
		logic padded;
	} od_side_t;

endpackage

// ===== rtl/core/rect_boundary_edge_endpoint_core.sv =====
// Square root, radius and offset divisions are each unrolled one bit per pipeline stage.
// Throughput: one item per cycle; a one-entry output skid buffer holds a
// result while out_ready is low, and the pipeline stalls only while it is full.
// Reset: arst_n clears all valid bits and sets gap_threshold to 10.0.
module rect_boundary_edge_endpoint_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [rbe_pkg::GW-1:0]         cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [rbe_pkg::POS_W-1:0] main_left,
	input  logic signed [rbe_pkg::POS_W-1:0] main_top,
	input  logic [rbe_pkg::SW-1:0]         main_width,
	input  logic [rbe_pkg::SW-1:0]         main_height,
	input  logic signed [rbe_pkg::POS_W-1:0] other_left,
	input  logic signed [rbe_pkg::POS_W-1:0] other_top,
	input  logic [rbe_pkg::SW-1:0]         other_width,
	input  logic [rbe_pkg::SW-1:0]         other_height,
	input  logic [rbe_pkg::PW-1:0]         main_padding,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [rbe_pkg::OUTW-1:0] end_x,
	output logic signed [rbe_pkg::OUTW-1:0] end_y,
	output logic                           padded
);
	import rbe_pkg::*;

	`include "rect_boundary_edge_endpoint_core_assert.svh"

	logic en;
	logic skid_v_q;
	logic [GW-1:0] gap_q;

	assign en       = !skid_v_q;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= GAP_RESET;
		end else if (cfg_we) begin
			gap_q <= cfg_wdata;
		end
	end

	// ---------------- stage 1: centres and axis distances
	logic signed [CW-1:0] mcx_c, mcy_c, ocx_c, ocy_c, mxe_c;
	logic signed [CW:0]   dx_c, dy_c;
	logic [CW:0]          mdx_c, mdy_c;
	logic                 coin_c;

	assign mcx_c = $signed({main_left[POS_W-1], main_left, 1'b0})
		+ $signed({{(CW-SW){1'b0}}, main_width});
	assign mcy_c = $signed({main_top[POS_W-1], main_top, 1'b0})
		+ $signed({{(CW-SW){1'b0}}, main_height});
	assign ocx_c = $signed({other_left[POS_W-1], other_left, 1'b0})
		+ $signed({{(CW-SW){1'b0}}, other_width});
	assign ocy_c = $signed({other_top[POS_W-1], other_top, 1'b0})
		+ $signed({{(CW-SW){1'b0}}, other_height});
	assign mxe_c = mcx_c + $signed({{(CW-SW){1'b0}}, main_width});
	assign dx_c  = $signed({ocx_c[CW-1], ocx_c}) - $signed({mcx_c[CW-1], mcx_c});
	assign dy_c  = $signed({ocy_c[CW-1], ocy_c}) - $signed({mcy_c[CW-1], mcy_c});
	assign mdx_c = dx_c[CW] ? -dx_c : dx_c;
	assign mdy_c = dy_c[CW] ? -dy_c : dy_c;
	assign coin_c = (dx_c == '0) && (dy_c == '0);

	logic   s1_v;
	pt_t    s1_pt;
	sizes_t s1_sz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
		end else if (en) begin
			s1_v <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s1_pt.coin <= coin_c;
			s1_pt.sx   <= dx_c[CW];
			s1_pt.sy   <= dy_c[CW];
			// coincident centres land on the right-edge midpoint
			s1_pt.bx   <= coin_c ? mxe_c : mcx_c;
			s1_pt.by   <= mcy_c;
			s1_pt.adx  <= mdx_c[AW-1:0];
			s1_pt.ady  <= mdy_c[AW-1:0];
			s1_pt.pad  <= main_padding;
			s1_sz.mw   <= main_width;
			s1_sz.mh   <= main_height;
			s1_sz.ow   <= other_width;
			s1_sz.oh   <= other_height;
		end
	end

	// ---------------- stage 2: squares and side-selection products
	logic              s2_v;
	pt_t               s2_pt;
	sizes_t            s2_sz;
	logic [2*AW-1:0]   s2_sqx, s2_sqy;
	logic [AW+SW-1:0]  s2_aym, s2_axm, s2_ayo, s2_axo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v <= 1'b0;
		end else if (en) begin
			s2_v <= s1_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s2_pt  <= s1_pt;
			s2_sz  <= s1_sz;
			s2_sqx <= s1_pt.adx * s1_pt.adx;
			s2_sqy <= s1_pt.ady * s1_pt.ady;
			s2_aym <= s1_pt.ady * s1_sz.mw;
			s2_axm <= s1_pt.adx * s1_sz.mh;
			s2_ayo <= s1_pt.ady * s1_sz.ow;
			s2_axo <= s1_pt.adx * s1_sz.oh;
		end
	end

	// ---------------- square root, one result bit per stage
	logic           sq_v    [SQ_N+1];
	logic [SQW-1:0] sq_rad  [SQ_N+1];
	logic [RMW-1:0] sq_rem  [SQ_N+1];
	logic [DW-1:0]  sq_root [SQ_N+1];
	sq_side_t       sq_side [SQ_N+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v[0] <= 1'b0;
		end else if (en) begin
			sq_v[0] <= s2_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_rad[0]        <= SQW'(s2_sqx) + SQW'(s2_sqy);
			sq_rem[0]        <= '0;
			sq_root[0]       <= '0;
			sq_side[0].pt    <= s2_pt;
			sq_side[0].sz    <= s2_sz;
			// vertical side is crossed when |dx| is nonzero and |dy|*w <= |dx|*h
			sq_side[0].sel_m <= (s2_pt.adx != '0) && (s2_aym <= s2_axm);
			sq_side[0].sel_o <= (s2_pt.adx != '0) && (s2_ayo <= s2_axo);
		end
	end

	for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
		logic [RMW+1:0] cur;
		logic [RMW+1:0] trial;
		logic           take;

		assign cur   = {sq_rem[k], sq_rad[k][SQW-1 -: 2]};
		assign trial = {2'b00, sq_root[k], 2'b01};
		assign take  = cur >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v[k+1] <= 1'b0;
			end else if (en) begin
				sq_v[k+1] <= sq_v[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_rad[k+1]  <= {sq_rad[k][SQW-3:0], 2'b00};
				sq_rem[k+1]  <= take ? RMW'(cur - trial) : cur[RMW-1:0];
				sq_root[k+1] <= {sq_root[k][DW-2:0], take};
				sq_side[k+1] <= sq_side[k];
			end
		end
	end

	// ---------------- radius dividends, then division, one bit per stage
	logic           rd_v     [RQW+1];
	logic [RNW-1:0] rd_rem_m [RQW+1];
	logic [RNW-1:0] rd_rem_o [RQW+1];
	logic [AW-1:0]  rd_den_m [RQW+1];
	logic [AW-1:0]  rd_den_o [RQW+1];
	logic [RQW-1:0] rd_q_m   [RQW+1];
	logic [RQW-1:0] rd_q_o   [RQW+1];
	rd_side_t       rd_side  [RQW+1];

	sq_side_t       sq_last;
	logic [DW-1:0]  d_c;

	assign sq_last = sq_side[SQ_N];
	assign d_c     = sq_root[SQ_N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v[0] <= 1'b0;
		end else if (en) begin
			rd_v[0] <= sq_v[SQ_N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rd_rem_m[0]   <= (sq_last.sel_m ? sq_last.sz.mw : sq_last.sz.mh) * d_c;
			rd_rem_o[0]   <= (sq_last.sel_o ? sq_last.sz.ow : sq_last.sz.oh) * d_c;
			rd_den_m[0]   <= sq_last.sel_m ? sq_last.pt.adx : sq_last.pt.ady;
			rd_den_o[0]   <= sq_last.sel_o ? sq_last.pt.adx : sq_last.pt.ady;
			rd_q_m[0]     <= '0;
			rd_q_o[0]     <= '0;
			rd_side[0].pt <= sq_last.pt;
			rd_side[0].d  <= d_c;
		end
	end

	for (genvar j = 0; j < RQW; j++) begin : g_rdiv
		localparam int SH = RQW - 1 - j;
		logic [RNW-1:0] trial_m, trial_o;
		logic           take_m, take_o;

		assign trial_m = RNW'(rd_den_m[j]) << SH;
		assign trial_o = RNW'(rd_den_o[j]) << SH;
		assign take_m  = rd_rem_m[j] >= trial_m;
		assign take_o  = rd_rem_o[j] >= trial_o;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rd_v[j+1] <= 1'b0;
			end else if (en) begin
				rd_v[j+1] <= rd_v[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rd_rem_m[j+1] <= take_m ? rd_rem_m[j] - trial_m : rd_rem_m[j];
				rd_rem_o[j+1] <= take_o ? rd_rem_o[j] - trial_o : rd_rem_o[j];
				rd_den_m[j+1] <= rd_den_m[j];
				rd_den_o[j+1] <= rd_den_o[j];
				rd_q_m[j+1]   <= {rd_q_m[j][RQW-2:0], take_m};
				rd_q_o[j+1]   <= {rd_q_o[j][RQW-2:0], take_o};
				rd_side[j+1]  <= rd_side[j];
			end
		end
	end

	// ---------------- padding decision
	rd_side_t        rd_last;
	logic [SUMW-1:0] rsum_c;
	logic            pad_c;

	assign rd_last = rd_side[RQW];
	assign rsum_c  = SUMW'(rd_q_m[RQW]) + SUMW'(rd_q_o[RQW]) + SUMW'({gap_q, 1'b0});
	assign pad_c   = rd_last.d > DW'(rsum_c);

	logic          pd_v;
	logic [TW-1:0] pd_rt;
	logic [DW-1:0] pd_d;
	od_side_t      pd_side;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pd_v <= 1'b0;
		end else if (en) begin
			pd_v <= rd_v[RQW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pd_rt          <= TW'(rd_q_m[RQW]) + (pad_c ? TW'({rd_last.pt.pad, 1'b0}) : '0);
			pd_d           <= rd_last.d;
			pd_side.pt     <= rd_last.pt;
			pd_side.padded <= pad_c;
		end
	end

	// ---------------- offset numerators
	logic           om_v;
	logic [PXW-1:0] om_px, om_py;
	logic [DW-1:0]  om_d;
	od_side_t       om_side;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			om_v <= 1'b0;
		end else if (en) begin
			om_v <= pd_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			om_px   <= pd_rt * pd_side.pt.adx;
			om_py   <= pd_rt * pd_side.pt.ady;
			om_d    <= pd_d;
			om_side <= pd_side;
		end
	end

	// ---------------- rounded offset division, one bit per stage
	logic           od_v    [OQW+1];
	logic [ONW-1:0] od_rem_x[OQW+1];
	logic [ONW-1:0] od_rem_y[OQW+1];
	logic [ODW-1:0] od_den  [OQW+1];
	logic [OQW-1:0] od_q_x  [OQW+1];
	logic [OQW-1:0] od_q_y  [OQW+1];
	od_side_t       od_side [OQW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			od_v[0] <= 1'b0;
		end else if (en) begin
			od_v[0] <= om_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// round to nearest: (2*num + d) / (2*d)
			od_rem_x[0] <= ONW'({om_px, 1'b0}) + ONW'(om_d);
			od_rem_y[0] <= ONW'({om_py, 1'b0}) + ONW'(om_d);
			od_den[0]   <= {om_d, 1'b0};
			od_q_x[0]   <= '0;
			od_q_y[0]   <= '0;
			od_side[0]  <= om_side;
		end
	end

	for (genvar j = 0; j < OQW; j++) begin : g_odiv
		localparam int SH = OQW - 1 - j;
		logic [ONW-1:0] trial;
		logic           take_x, take_y;

		assign trial  = ONW'(od_den[j]) << SH;
		assign take_x = od_rem_x[j] >= trial;
		assign take_y = od_rem_y[j] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				od_v[j+1] <= 1'b0;
			end else if (en) begin
				od_v[j+1] <= od_v[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				od_rem_x[j+1] <= take_x ? od_rem_x[j] - trial : od_rem_x[j];
				od_rem_y[j+1] <= take_y ? od_rem_y[j] - trial : od_rem_y[j];
				od_den[j+1]   <= od_den[j];
				od_q_x[j+1]   <= {od_q_x[j][OQW-2:0], take_x};
				od_q_y[j+1]   <= {od_q_y[j][OQW-2:0], take_y};
				od_side[j+1]  <= od_side[j];
			end
		end
	end

	// ---------------- endpoint in half units, plus one for round-half-up
	od_side_t             od_last;
	logic signed [FW-1:0] offx_c, offy_c;

	assign od_last = od_side[OQW];

	always_comb begin
		if (od_last.pt.coin) begin
			offx_c = '0;
			offy_c = '0;
		end else begin
			offx_c = od_last.pt.sx ? -$signed(FW'(od_q_x[OQW])) : $signed(FW'(od_q_x[OQW]));
			offy_c = od_last.pt.sy ? -$signed(FW'(od_q_y[OQW])) : $signed(FW'(od_q_y[OQW]));
		end
	end

	logic                 f_v;
	logic signed [FW-1:0] f_x, f_y;
	logic                 f_padded;
	logic                 f_coin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_v <= 1'b0;
		end else if (en) begin
			f_v <= od_v[OQW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f_x      <= FW'(od_last.pt.bx) + offx_c + FW'(1);
			f_y      <= FW'(od_last.pt.by) + offy_c + FW'(1);
			f_padded <= od_last.padded;
			f_coin   <= od_last.pt.coin;
		end
	end

	// ---------------- halve and saturate
	logic [FW-2:0]    hx_c, hy_c;
	logic [OUTW-1:0]  sx_c, sy_c;
	localparam logic [OUTW-1:0] OUT_MAX = {1'b0, {(OUTW-1){1'b1}}};
	localparam logic [OUTW-1:0] OUT_MIN = {1'b1, {(OUTW-1){1'b0}}};

	assign hx_c = f_x[FW-1:1];
	assign hy_c = f_y[FW-1:1];

	always_comb begin
		if (!hx_c[FW-2] && (hx_c[FW-3:OUTW-1] != '0)) begin
			sx_c = OUT_MAX;
		end else if (hx_c[FW-2] && (hx_c[FW-3:OUTW-1] != '1)) begin
			sx_c = OUT_MIN;
		end else begin
			sx_c = hx_c[OUTW-1:0];
		end
		if (!hy_c[FW-2] && (hy_c[FW-3:OUTW-1] != '0)) begin
			sy_c = OUT_MAX;
		end else if (hy_c[FW-2] && (hy_c[FW-3:OUTW-1] != '1)) begin
			sy_c = OUT_MIN;
		end else begin
			sy_c = hy_c[OUTW-1:0];
		end
	end

	logic            o_v;
	logic [OUTW-1:0] o_x, o_y;
	logic            o_padded;
	logic            o_coin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_v <= 1'b0;
		end else if (en) begin
			o_v <= f_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			o_x      <= sx_c;
			o_y      <= sy_c;
			o_padded <= f_padded;
			o_coin   <= f_coin;
		end
	end

	// ---------------- output skid buffer
	logic [OUTW-1:0] skid_x_q, skid_y_q;
	logic            skid_padded_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (out_ready) begin
				skid_v_q <= 1'b0;
			end
		end else if (o_v && !out_ready) begin
			// park the stalled item, pipeline advances this cycle
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			skid_x_q      <= o_x;
			skid_y_q      <= o_y;
			skid_padded_q <= o_padded;
		end
	end

	assign out_valid = skid_v_q || o_v;
	assign end_x     = skid_v_q ? skid_x_q : o_x;
	assign end_y     = skid_v_q ? skid_y_q : o_y;
	assign padded    = skid_v_q ? skid_padded_q : o_padded;

	`RBE_ASSERT_NEXT(a_skid_load, en && o_v && !out_ready, skid_v_q)
	`RBE_ASSERT_NEXT(a_skid_drain, skid_v_q && out_ready, !skid_v_q)
	`RBE_ASSERT_IMPL(a_coin_unpadded, o_v && o_coin, !o_padded)

endmodule

// ===== dv/rect_boundary_edge_endpoint_core_tb.sv =====
// Testbench for the rect boundary endpoint core: a scoreboard class, stimulus tasks and checks
module rect_boundary_edge_endpoint_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rbe_pkg::*;

	typedef struct {
		logic signed [POS_W-1:0] ml, mt, ol, ot;
		logic [SW-1:0]           mw, mh, ow, oh;
		logic [PW-1:0]           pad;
	} box_query_t;

	typedef struct {
		logic signed [OUTW-1:0] x, y;
		logic                   padded;
	} endpoint_t;

	localparam longint POS_MAX = 4194303;
	localparam longint POS_MIN = -4194304;
	localparam longint SZ_MAX = 4194303;
	localparam int DRAIN_CYCLES = 100;
	localparam int STALL_LIMIT = 5000;

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// distance from the centre to the box boundary along the ray
	function automatic longint edge_distance(longint w, longint h, longint adx, longint ady,
			longint d);
		if (adx != 0 && ady * w <= adx * h)
			return (w * d) / adx;
		if (ady == 0)
			return 0;
		return (h * d) / ady;
	endfunction

	function automatic longint div_nearest(longint num, longint den);
		longint mag, q;
		mag = (num < 0) ? -num : num;
		q = (2 * mag + den) / (2 * den);
		return (num < 0) ? -q : q;
	endfunction

	// halve with rounding half up, then clamp to the output range
	function automatic logic signed [OUTW-1:0] halve_sat(longint v);
		longint r;
		r = (v + 1) >>> 1;
		if (r > 8388607)
			r = 8388607;
		if (r < -8388608)
			r = -8388608;
		return r[OUTW-1:0];
	endfunction

	function automatic endpoint_t predict_endpoint(box_query_t q, logic [GW-1:0] gap);
		endpoint_t e;
		longint cx, cy, dx, dy, adx, ady, d, rm, ro, rt;
		longint mw, mh, ow, oh;
		logic pd;
		mw = q.mw; mh = q.mh; ow = q.ow; oh = q.oh;
		cx = 2 * longint'(q.ml) + mw;
		cy = 2 * longint'(q.mt) + mh;
		dx = 2 * longint'(q.ol) + ow - cx;
		dy = 2 * longint'(q.ot) + oh - cy;
		if (dx == 0 && dy == 0) begin
			e.x = halve_sat(cx + mw);
			e.y = halve_sat(cy);
			e.padded = 1'b0;
			return e;
		end
		adx = (dx < 0) ? -dx : dx;
		ady = (dy < 0) ? -dy : dy;
		d = longint'(int_sqrt(adx * adx + ady * ady));
		rm = edge_distance(mw, mh, adx, ady, d);
		ro = edge_distance(ow, oh, adx, ady, d);
		pd = d > rm + ro + 2 * longint'(gap);
		rt = rm + (pd ? 2 * longint'(q.pad) : 0);
		e.x = halve_sat(cx + div_nearest(rt * dx, d));
		e.y = halve_sat(cy + div_nearest(rt * dy, d));
		e.padded = pd;
		return e;
	endfunction

	class endpoint_scoreboard;
		endpoint_t endpoint_q[$];
		logic [GW-1:0] gap;
		int mismatches;

		function void note_item(box_query_t q);
			endpoint_q.push_back(predict_endpoint(q, gap));
		endfunction

		function void check_result(logic signed [OUTW-1:0] x, logic signed [OUTW-1:0] y,
				logic p);
			endpoint_t e;
			if (endpoint_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result x=%0d y=%0d padded=%0b", x, y, p);
				return;
			end
			e = endpoint_q.pop_front();
			if (x !== e.x || y !== e.y || p !== e.padded) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result mismatch: expected x=%0d y=%0d padded=%0b, got x=%0d y=%0d padded=%0b",
						e.x, e.y, e.padded, x, y, p);
			end
		endfunction
	endclass

	logic clk, arst_n, cfg_we, in_valid, in_ready, out_valid, out_ready;
	logic [GW-1:0] cfg_wdata;
	logic signed [POS_W-1:0] main_left, main_top, other_left, other_top;
	logic [SW-1:0] main_width, main_height, other_width, other_height;
	logic [PW-1:0] main_padding;
	logic signed [OUTW-1:0] end_x, end_y;
	logic padded;

	endpoint_scoreboard sb;
	bit sender_idles, receiver_stalls;
	int quiet_cycles;

	rect_boundary_edge_endpoint_core i_dut (
		.clk, .arst_n, .cfg_we, .cfg_wdata, .in_valid, .in_ready,
		.main_left, .main_top, .main_width, .main_height,
		.other_left, .other_top, .other_width, .other_height, .main_padding,
		.out_valid, .out_ready, .end_x, .end_y, .padded
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic box_query_t mk(longint ml, longint mt, longint mw, longint mh,
			longint ol, longint ot, longint ow, longint oh, longint pad);
		box_query_t q;
		q.ml = ml[POS_W-1:0]; q.mt = mt[POS_W-1:0];
		q.mw = mw[SW-1:0]; q.mh = mh[SW-1:0];
		q.ol = ol[POS_W-1:0]; q.ot = ot[POS_W-1:0];
		q.ow = ow[SW-1:0]; q.oh = oh[SW-1:0];
		q.pad = pad[PW-1:0];
		return q;
	endfunction

	function automatic longint near_coord();
		return longint'($urandom_range(0, 32767)) - 16384;
	endfunction

	function automatic box_query_t random_query();
		box_query_t q;
		int mode;
		mode = $urandom_range(0, 9);
		if (mode < 3) begin
			q = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom);
		end else begin
			q = mk(near_coord(), near_coord(), $urandom_range(0, 4095), $urandom_range(0, 4095),
				near_coord(), near_coord(), $urandom_range(0, 4095), $urandom_range(0, 4095),
				$urandom);
			if ($urandom_range(0, 7) == 0) begin
				q.mw = 0;
				q.oh = 0;
			end
			if (mode == 8) begin
				// same centre in x or in both axes
				q.ol = q.ml;
				q.ow = q.mw;
				if ($urandom_range(0, 1))
					q.ot = q.mt;
				if ($urandom_range(0, 1))
					q.oh = q.mh;
			end else if (mode == 9) begin
				q.ot = q.mt;
				q.oh = q.mh;
			end
		end
		return q;
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_query(box_query_t q);
		if (sender_idles && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		main_left <= q.ml; main_top <= q.mt; main_width <= q.mw; main_height <= q.mh;
		other_left <= q.ol; other_top <= q.ot; other_width <= q.ow; other_height <= q.oh;
		main_padding <= q.pad;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		sb.note_item(q);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.endpoint_q.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_gap(logic [GW-1:0] v);
		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.gap = v;
	endtask

	// receiver
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (receiver_stalls && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(negedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(0, 20)) @(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(end_x, end_y, padded);
	end

	// watchdog on cycles with no accepted item on either side
	initial begin
		quiet_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		box_query_t directed[$];
		logic [GW-1:0] gaps[4];
		sb = new();
		sb.gap = GAP_RESET;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		main_left = '0; main_top = '0; main_width = '0; main_height = '0;
		other_left = '0; other_top = '0; other_width = '0; other_height = '0;
		main_padding = '0;
		sender_idles = 1'b1;
		receiver_stalls = 1'b1;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		directed.push_back(mk(0, 0, 100, 100, 0, 0, 100, 100, 0));
		directed.push_back(mk(POS_MAX, POS_MAX, SZ_MAX, SZ_MAX, POS_MAX, POS_MAX, SZ_MAX,
			SZ_MAX, 65535));
		directed.push_back(mk(POS_MIN, POS_MIN, 0, 0, POS_MIN, POS_MIN, 0, 0, 65535));
		directed.push_back(mk(0, 0, 512, 512, 0, 5000, 512, 512, 256));
		directed.push_back(mk(0, 0, 512, 512, 0, -5000, 512, 512, 256));
		directed.push_back(mk(0, 0, 512, 512, 5000, 0, 512, 512, 256));
		directed.push_back(mk(0, 0, 512, 512, -5000, 0, 512, 512, 256));
		directed.push_back(mk(0, 0, 1000, 1000, 3000, 3000, 1000, 1000, 100));
		directed.push_back(mk(0, 0, 1000, 1000, -3000, 3000, 1000, 1000, 100));
		directed.push_back(mk(0, 0, 0, 0, 1000, 700, 0, 0, 65535));
		directed.push_back(mk(0, 0, 0, 0, 0, -1000, 0, 0, 5));
		directed.push_back(mk(0, 0, 0, 800, 0, 1000, 0, 0, 5));
		directed.push_back(mk(POS_MIN, POS_MIN, 0, 0, POS_MAX, POS_MAX, SZ_MAX, SZ_MAX, 65535));
		directed.push_back(mk(POS_MAX, POS_MAX, SZ_MAX, SZ_MAX, POS_MIN, POS_MIN, 0, 0, 65535));
		directed.push_back(mk(POS_MIN, POS_MAX, SZ_MAX, 0, POS_MAX, POS_MIN, 0, SZ_MAX, 0));
		directed.push_back(mk(POS_MAX, 0, SZ_MAX, 0, POS_MAX, 1, SZ_MAX, 0, 65535));
		directed.push_back(mk(POS_MIN, 0, 0, 0, POS_MIN, 1, 0, 0, 65535));
		directed.push_back(mk(0, 0, 256, 256, -4000, -3000, 256, 256, 1000));
		directed.push_back(mk(0, 0, 256, 256, 4000, -3000, 256, 256, 1000));
		directed.push_back(mk(0, 0, 2560, 2560, 5120, 0, 2560, 2560, 300));
		directed.push_back(mk(0, 0, 2560, 2560, 5121, 0, 2560, 2560, 300));
		foreach (directed[i])
			send_query(directed[i]);

		gaps[0] = '0;
		gaps[1] = '1;
		gaps[2] = $urandom;
		gaps[3] = GAP_RESET;
		for (int ph = 0; ph < 4; ph++) begin
			write_gap(gaps[ph]);
			if (ph == 0)
				foreach (directed[i])
					send_query(directed[i]);
			if (ph == 3) begin
				sender_idles = 1'b0;
				receiver_stalls = 1'b0;
			end
			for (int n = 0; n < 460; n++) begin
				if (ph == 1 && n == 200)
					wait_drained();
				send_query(random_query());
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0 && sb.endpoint_q.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule

// ===== rect_boundary_edge_endpoint_core.f =====
+incdir+rtl/core
rtl/core/rbe_pkg.sv
rtl/core/rect_boundary_edge_endpoint_core.sv
dv/rect_boundary_edge_endpoint_core_tb.sv
